// ===== sv/pmm_pkg.sv =====
package pmm_pkg;

    localparam int MASS_W  = 58;
    localparam int H_CNT_W = 14;
    localparam int C_CNT_W = 14;
    localparam int N_CNT_W = 13;
    localparam int O_CNT_W = 12;
    localparam int S_CNT_W = 11;

    localparam int DEF_MAX_RESIDUES  = 1024;
    localparam int DEF_FRACTION_BITS = 40;

    localparam int NUM_CODES = 21;
    localparam int IDX_W     = $clog2(NUM_CODES);

    localparam longint unsigned DEC_DEN    = 64'd100000000000;
    localparam longint unsigned MASS_H_DEC = 64'd100782503207;
    localparam longint unsigned MASS_C_DEC = 64'd1200000000000;
    localparam longint unsigned MASS_N_DEC = 64'd1400307400480;
    localparam longint unsigned MASS_O_DEC = 64'd1599491461956;
    localparam longint unsigned MASS_S_DEC = 64'd3197207100000;

    typedef struct packed {
        logic [7:0] residue;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [MASS_W-1:0]  mass_fixed;
        logic [H_CNT_W-1:0] hydrogen_count;
        logic [C_CNT_W-1:0] carbon_count;
        logic [N_CNT_W-1:0] nitrogen_count;
        logic [O_CNT_W-1:0] oxygen_count;
        logic [S_CNT_W-1:0] sulfur_count;
        logic               too_long;
    } t_out;

    typedef struct packed {
        logic [3:0] h;
        logic [3:0] c;
        logic [2:0] n;
        logic [1:0] o;
        logic       s;
    } t_atoms;

    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_item;

    typedef logic [MASS_W-1:0] t_mass_tab [NUM_CODES];

    localparam logic [7:0] CODES [NUM_CODES] = '{
        8'h41, 8'h43, 8'h63, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4B, 8'h4C,
        8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h56, 8'h57, 8'h59
    };

    localparam t_atoms ATOMS [NUM_CODES] = '{
        '{4'd5,  4'd3,  3'd1, 2'd1, 1'b0},
        '{4'd5,  4'd3,  3'd1, 2'd1, 1'b1},
        '{4'd8,  4'd5,  3'd2, 2'd2, 1'b1},
        '{4'd5,  4'd4,  3'd1, 2'd3, 1'b0},
        '{4'd7,  4'd5,  3'd1, 2'd3, 1'b0},
        '{4'd9,  4'd9,  3'd1, 2'd1, 1'b0},
        '{4'd3,  4'd2,  3'd1, 2'd1, 1'b0},
        '{4'd7,  4'd6,  3'd3, 2'd1, 1'b0},
        '{4'd11, 4'd6,  3'd1, 2'd1, 1'b0},
        '{4'd12, 4'd6,  3'd2, 2'd1, 1'b0},
        '{4'd11, 4'd6,  3'd1, 2'd1, 1'b0},
        '{4'd9,  4'd5,  3'd1, 2'd1, 1'b1},
        '{4'd6,  4'd4,  3'd2, 2'd2, 1'b0},
        '{4'd7,  4'd5,  3'd1, 2'd1, 1'b0},
        '{4'd8,  4'd5,  3'd2, 2'd2, 1'b0},
        '{4'd12, 4'd6,  3'd4, 2'd1, 1'b0},
        '{4'd5,  4'd3,  3'd1, 2'd2, 1'b0},
        '{4'd7,  4'd4,  3'd1, 2'd2, 1'b0},
        '{4'd9,  4'd5,  3'd1, 2'd1, 1'b0},
        '{4'd10, 4'd11, 3'd2, 2'd1, 1'b0},
        '{4'd9,  4'd9,  3'd1, 2'd2, 1'b0}
    };

    function automatic longint unsigned fixed_mass(longint unsigned num, int frac);
        longint unsigned q;
        longint unsigned rem;
        longint unsigned acc;
        int              i;
        q   = num / DEC_DEN;
        rem = num % DEC_DEN;
        acc = 0;
        for (i = 0; i <= frac; i++) begin
            rem = rem << 1;
            acc = acc << 1;
            if (rem >= DEC_DEN) begin
                rem = rem - DEC_DEN;
                acc = acc | 64'd1;
            end
        end
        return (q << frac) + ((acc + 64'd1) >> 1);
    endfunction

    function automatic t_mass_tab residue_mass_rom(int frac);
        t_mass_tab       tab;
        longint unsigned sum;
        int              i;
        for (i = 0; i < NUM_CODES; i++) begin
            sum = 64'(ATOMS[i].h) * fixed_mass(MASS_H_DEC, frac)
                + 64'(ATOMS[i].c) * fixed_mass(MASS_C_DEC, frac)
                + 64'(ATOMS[i].n) * fixed_mass(MASS_N_DEC, frac)
                + 64'(ATOMS[i].o) * fixed_mass(MASS_O_DEC, frac)
                + 64'(ATOMS[i].s) * fixed_mass(MASS_S_DEC, frac);
            tab[i] = sum[MASS_W-1:0];
        end
        return tab;
    endfunction

    function automatic logic [MASS_W-1:0] water_mass(int frac);
        longint unsigned sum;
        sum = 64'd2 * fixed_mass(MASS_H_DEC, frac) + fixed_mass(MASS_O_DEC, frac);
        return sum[MASS_W-1:0];
    endfunction

endpackage

// ===== sv/pmm_in_stage.sv =====
module pmm_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  pmm_pkg::t_in  i_in,
    output logic          o_in_stall,
    input  logic          i_take,
    output pmm_pkg::t_item o_item
);
    import pmm_pkg::*;

    logic             r_vld;
    logic             r_hit;
    logic [IDX_W-1:0] r_idx;
    logic             r_last;
    logic             n_hit;
    logic [IDX_W-1:0] n_idx;

    always_comb begin
        n_hit = 1'b0;
        n_idx = '0;
        for (int i = 0; i < NUM_CODES; i++) begin
            if (i_in.residue == CODES[i]) begin
                n_hit = 1'b1;
                n_idx = IDX_W'(i);
            end
        end
    end

    assign o_in_stall = r_vld && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_hit  <= n_hit;
            r_idx  <= n_idx;
            r_last <= i_in.last;
        end
    end

    assign o_item = '{vld: r_vld, hit: r_hit, idx: r_idx, last: r_last};

endmodule

// ===== sv/pmm_accum.sv =====
module pmm_accum #(
    parameter int MAX_RESIDUES  = pmm_pkg::DEF_MAX_RESIDUES,
    parameter int FRACTION_BITS = pmm_pkg::DEF_FRACTION_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pmm_pkg::t_item i_item,
    output logic           o_take,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pmm_pkg::t_out  o_out
);
    import pmm_pkg::*;

    localparam int RES_W  = $clog2(MAX_RESIDUES + 1);
    localparam int H_NEED = $clog2(12 * MAX_RESIDUES + 3);
    localparam int C_NEED = $clog2(11 * MAX_RESIDUES + 1);
    localparam int N_NEED = $clog2(4 * MAX_RESIDUES + 1);
    localparam int O_NEED = $clog2(3 * MAX_RESIDUES + 2);
    localparam int S_NEED = $clog2(MAX_RESIDUES + 1);
    localparam int H_W = (H_NEED > H_CNT_W) ? H_NEED : H_CNT_W;
    localparam int C_W = (C_NEED > C_CNT_W) ? C_NEED : C_CNT_W;
    localparam int N_W = (N_NEED > N_CNT_W) ? N_NEED : N_CNT_W;
    localparam int O_W = (O_NEED > O_CNT_W) ? O_NEED : O_CNT_W;
    localparam int S_W = (S_NEED > S_CNT_W) ? S_NEED : S_CNT_W;

    localparam t_mass_tab         RES_MASS = residue_mass_rom(FRACTION_BITS);
    localparam logic [MASS_W-1:0] WATER    = water_mass(FRACTION_BITS);

    logic [H_W-1:0]    r_h, n_h;
    logic [C_W-1:0]    r_c, n_c;
    logic [N_W-1:0]    r_n, n_n;
    logic [O_W-1:0]    r_o, n_o;
    logic [S_W-1:0]    r_s, n_s;
    logic [MASS_W-1:0] r_mass, n_mass;
    logic [RES_W-1:0]  r_res, n_res;
    logic              r_ovf, n_ovf;
    logic              r_out_vld;
    t_out              r_out;
    logic              out_free;
    logic              full;
    logic              add;
    t_atoms            atoms;

    assign out_free = !r_out_vld || !i_out_stall;
    assign o_take   = i_item.vld && (!i_item.last || out_free);
    assign full     = r_res >= RES_W'(MAX_RESIDUES);
    assign add      = !full && i_item.hit;
    assign atoms    = ATOMS[i_item.idx];

    always_comb begin
        n_h    = r_h + (add ? H_W'(atoms.h) : '0);
        n_c    = r_c + (add ? C_W'(atoms.c) : '0);
        n_n    = r_n + (add ? N_W'(atoms.n) : '0);
        n_o    = r_o + (add ? O_W'(atoms.o) : '0);
        n_s    = r_s + (add ? S_W'(atoms.s) : '0);
        n_mass = r_mass + (add ? RES_MASS[i_item.idx] : '0);
        n_res  = full ? r_res : r_res + RES_W'(1);
        n_ovf  = r_ovf | full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_item.last)) begin
            r_h    <= H_W'(2);
            r_c    <= '0;
            r_n    <= '0;
            r_o    <= O_W'(1);
            r_s    <= '0;
            r_mass <= WATER;
            r_res  <= '0;
            r_ovf  <= 1'b0;
        end else if (o_take) begin
            r_h    <= n_h;
            r_c    <= n_c;
            r_n    <= n_n;
            r_o    <= n_o;
            r_s    <= n_s;
            r_mass <= n_mass;
            r_res  <= n_res;
            r_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_take && i_item.last) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last) begin
            r_out <= '{mass_fixed:     n_mass,
                       hydrogen_count: n_h[H_CNT_W-1:0],
                       carbon_count:   n_c[C_CNT_W-1:0],
                       nitrogen_count: n_n[N_CNT_W-1:0],
                       oxygen_count:   n_o[O_CNT_W-1:0],
                       sulfur_count:   n_s[S_CNT_W-1:0],
                       too_long:       n_ovf};
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

`ifndef SYNTH
    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res <= RES_W'(MAX_RESIDUES))
        else $error("residue count beyond limit");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_res == RES_W'(MAX_RESIDUES)))
        else $error("overflow flag without full count");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.last) |=> r_out_vld)
        else $error("last beat produced no result");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.last) |=> (r_h == H_W'(2) && r_o == O_W'(1) && r_res == '0
                                     && r_mass == WATER && !r_ovf))
        else $error("totals not cleared after last beat");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.vld && i_item.last && r_out_vld && i_out_stall) |-> !o_take)
        else $error("last beat taken while result held");
`endif

endmodule

// ===== sv/peptide_monoisotopic_mass_unit.sv =====
// Result: a last residue beat is registered in the input stage, and when the
// accumulator takes it, the result and its valid flag are registered at the output.
// Throughput: one residue beat per cycle; a last beat waits only while a
// previous result is still held at the output.
// Reset: synchronous, active low; presets the totals to one water molecule and
// clears the residue count, the overflow flag and both valid flags.
module peptide_monoisotopic_mass_unit #(
    parameter int MAX_RESIDUES  = pmm_pkg::DEF_MAX_RESIDUES,
    parameter int FRACTION_BITS = pmm_pkg::DEF_FRACTION_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pmm_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pmm_pkg::t_out o_out
);
    import pmm_pkg::*;

    t_item item;
    logic  take;

    pmm_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_take     (take),
        .o_item     (item)
    );

    pmm_accum #(
        .MAX_RESIDUES  (MAX_RESIDUES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
